>>> hdl/oce_pkg.sv
`timescale 1ns / 1ps

package oce_pkg;

	typedef struct packed {
		logic [7:0]  row_index;
		logic [7:0]  col_index;
		logic [31:0] row_time;
		logic [31:0] col_time;
		logic [31:0] shared_time;
	} oce_in_t;

	typedef struct packed {
		logic [7:0]  out_row;
		logic [7:0]  out_col;
		logic [31:0] covariance;
		logic        zero_alpha_error;
	} oce_out_t;

	typedef logic [0:0] cfg_index_t;

	localparam cfg_index_t  CFG_ALPHA_SQ = 1'b0;
	localparam cfg_index_t  CFG_SIGMA_SQ = 1'b1;
	localparam logic [31:0] ALPHA_RESET  = 32'h0001_0000;
	localparam logic [31:0] SIGMA_RESET  = 32'h0001_0000;
	localparam logic [31:0] LOG2E_FRAC   = 32'd1901360723;
	localparam logic [31:0] FULL_SCALE   = 32'hFFFF_FFFF;
	localparam int          POW_STEPS    = 16;
	localparam int          DIV_STEPS    = 96;

	// q1.31 root 2^(2^-j), each the rounded square root of the one above
	function automatic logic [63:0] pow2_root(input int j);
		logic [63:0] r_prev;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bit_w;
		r_prev = 64'h0000_0001_0000_0000;
		for (int i = 1; i <= j; i++) begin
			n = r_prev << 31;
			res = 64'd0;
			rem = n;
			bit_w = 64'h4000_0000_0000_0000;
			for (int b = 0; b < 32; b++) begin
				if (rem >= res + bit_w) begin
					rem = rem - (res + bit_w);
					res = (res >> 1) + bit_w;
				end else begin
					res = res >> 1;
				end
				bit_w = bit_w >> 2;
			end
			if (n - res * res > res) begin
				res = res + 64'd1;
			end
			r_prev = res;
		end
		return r_prev;
	endfunction

endpackage

>>> hdl/ou_covariance_element_top.sv
`timescale 1ns / 1ps

// pipeline: 7 front stages, 16 exp stages, one product stage, 96 divider stages
// and 3 more: scale, saturation and the output register
// throughput: one item per cycle; a full two-entry output buffer raises in_stall
// reset: arst_n clears all valid bits and loads alpha_sq and sigma_sq with 1.0
module ou_covariance_element_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  oce_pkg::oce_in_t      in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output oce_pkg::oce_out_t     out_item,
	input  logic                  cfg_we,
	input  oce_pkg::cfg_index_t   cfg_index,
	input  logic [31:0]           cfg_data
);

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
	} idx_t;

	typedef struct packed {
		idx_t       idx;
		logic       sat;
		logic       zero;
		logic [6:0] sh;
	} ctl_t;

	logic [31:0] alpha_q;
	logic [31:0] sigma_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= oce_pkg::ALPHA_RESET;
			sigma_q <= oce_pkg::SIGMA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				oce_pkg::CFG_ALPHA_SQ: alpha_q <= cfg_data;
				oce_pkg::CFG_SIGMA_SQ: sigma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: |d| and sign
	logic [33:0] sum_c, tw_c;
	logic        v_s1, grow_s1;
	logic [33:0] ad_s1;
	idx_t        idx_s1;

	assign sum_c = {2'b00, in_item.row_time} + {2'b00, in_item.col_time};
	assign tw_c  = {1'b0, in_item.shared_time, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			grow_s1 <= sum_c < tw_c;
			ad_s1   <= (sum_c < tw_c) ? tw_c - sum_c : sum_c - tw_c;
			idx_s1  <= '{row: in_item.row_index, col: in_item.col_index};
		end
	end

	// stage 2: alpha * low word of |d|
	logic        v_s2, grow_s2;
	logic [63:0] plo_s2;
	logic [1:0]  adhi_s2;
	idx_t        idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2    <= v_s1;
			grow_s2 <= grow_s1;
			plo_s2  <= 64'(alpha_q) * 64'(ad_s1[31:0]);
			adhi_s2 <= ad_s1[33:32];
			idx_s2  <= idx_s1;
		end
	end

	// stage 3: x = alpha * |d| in q16.16
	logic        v_s3, grow_s3;
	logic [49:0] x_s3;
	idx_t        idx_s3;
	logic [33:0] phi_c;

	assign phi_c = 34'(alpha_q) * 34'(adhi_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3    <= v_s2;
			grow_s3 <= grow_s2;
			x_s3    <= 50'(plo_s2[63:16]) + (50'(phi_c) << 16);
			idx_s3  <= idx_s2;
		end
	end

	// stage 4: low word times log2(e) fraction
	logic        v_s4, grow_s4;
	logic [49:0] x_s4;
	logic [63:0] ml_s4;
	idx_t        idx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4    <= v_s3;
			grow_s4 <= grow_s3;
			x_s4    <= x_s3;
			ml_s4   <= 64'(x_s3[31:0]) * 64'(oce_pkg::LOG2E_FRAC);
			idx_s4  <= idx_s3;
		end
	end

	// stage 5: high word times log2(e) fraction
	logic        v_s5, grow_s5;
	logic [49:0] x_s5;
	logic [31:0] mlh_s5;
	logic [49:0] mh_s5;
	idx_t        idx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5    <= v_s4;
			grow_s5 <= grow_s4;
			x_s5    <= x_s4;
			mlh_s5  <= ml_s4[63:32];
			mh_s5   <= 50'(x_s4[49:32]) * 50'(oce_pkg::LOG2E_FRAC);
			idx_s5  <= idx_s4;
		end
	end

	// stage 6: y = x * log2(e)
	logic        v_s6, grow_s6;
	logic [50:0] y_s6;
	idx_t        idx_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6    <= v_s5;
			grow_s6 <= grow_s5;
			y_s6    <= 51'(x_s5) + 51'(mh_s5) + 51'(mlh_s5);
			idx_s6  <= idx_s5;
		end
	end

	// stage 7: exponent split into shift and fraction
	logic [34:0]        k_c;
	logic [15:0]        f_c;
	logic signed [36:0] shv_c;
	logic [15:0]        g_c;

	assign k_c = y_s6[50:16];
	assign f_c = y_s6[15:0];

	always_comb begin
		if (grow_s6) begin
			shv_c = 37'sd48 - $signed({2'b00, k_c});
			g_c   = f_c;
		end else if (f_c == 16'd0) begin
			shv_c = 37'sd48 + $signed({2'b00, k_c});
			g_c   = 16'd0;
		end else begin
			shv_c = 37'sd49 + $signed({2'b00, k_c});
			g_c   = 16'(17'h1_0000 - 17'(f_c));
		end
	end

	logic        pw_v [0:oce_pkg::POW_STEPS];
	logic [31:0] pw_m [0:oce_pkg::POW_STEPS];
	logic [15:0] pw_g [0:oce_pkg::POW_STEPS];
	ctl_t        pw_c [0:oce_pkg::POW_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_v[0] <= 1'b0;
		end else if (en) begin
			pw_v[0] <= v_s6;
			pw_m[0] <= 32'h8000_0000;
			pw_g[0] <= g_c;
			pw_c[0] <= '{idx: idx_s6, sat: shv_c < 37'sd0,
				zero: shv_c >= 37'sd96, sh: shv_c[6:0]};
		end
	end

	// 2^(g/65536) one fraction bit per stage, msb first
	for (genvar j = 1; j <= oce_pkg::POW_STEPS; j++) begin : g_pow
		localparam logic [31:0] ROOT = 32'(oce_pkg::pow2_root(j));
		logic [63:0] prod;
		logic [64:0] rnd;

		assign prod = 64'(pw_m[j-1]) * 64'(ROOT);
		assign rnd  = {1'b0, prod} + (65'd1 << 30);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pw_v[j] <= 1'b0;
			end else if (en) begin
				pw_v[j] <= pw_v[j-1];
				pw_m[j] <= pw_g[j-1][oce_pkg::POW_STEPS-j] ? rnd[62:31] : pw_m[j-1];
				pw_g[j] <= pw_g[j-1];
				pw_c[j] <= pw_c[j-1];
			end
		end
	end

	// divider: floor(sigma * m * 2^32 / alpha), one quotient bit per stage
	logic        dv_v  [0:oce_pkg::DIV_STEPS];
	logic [95:0] dv_nq [0:oce_pkg::DIV_STEPS];
	logic [31:0] dv_r  [0:oce_pkg::DIV_STEPS];
	ctl_t        dv_c  [0:oce_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0]  <= pw_v[oce_pkg::POW_STEPS];
			dv_nq[0] <= {64'(sigma_q) * 64'(pw_m[oce_pkg::POW_STEPS]), 32'd0};
			dv_r[0]  <= 32'd0;
			dv_c[0]  <= pw_c[oce_pkg::POW_STEPS];
		end
	end

	for (genvar j = 1; j <= oce_pkg::DIV_STEPS; j++) begin : g_div
		logic [32:0] t;
		logic [32:0] diff;
		logic        ge;

		assign t    = {dv_r[j-1], dv_nq[j-1][95]};
		assign ge   = t >= {1'b0, alpha_q};
		assign diff = t - {1'b0, alpha_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (en) begin
				dv_v[j]  <= dv_v[j-1];
				dv_r[j]  <= ge ? diff[31:0] : t[31:0];
				dv_nq[j] <= {dv_nq[j-1][94:0], ge};
				dv_c[j]  <= dv_c[j-1];
			end
		end
	end

	// scale by the power of two
	logic        v_s8;
	logic [95:0] qs_s8;
	ctl_t        ctl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8   <= dv_v[oce_pkg::DIV_STEPS];
			qs_s8  <= dv_nq[oce_pkg::DIV_STEPS] >> dv_c[oce_pkg::DIV_STEPS].sh;
			ctl_s8 <= dv_c[oce_pkg::DIV_STEPS];
		end
	end

	// saturation and special values
	logic              v_s9;
	oce_pkg::oce_out_t res_s9;
	logic [31:0]       cov_c;

	always_comb begin
		if (alpha_q == 32'd0 || sigma_q == 32'd0 || ctl_s8.zero) begin
			cov_c = 32'd0;
		end else if (ctl_s8.sat || qs_s8[95:32] != 64'd0) begin
			cov_c = oce_pkg::FULL_SCALE;
		end else begin
			cov_c = qs_s8[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9   <= v_s8;
			res_s9 <= '{out_row: ctl_s8.idx.row, out_col: ctl_s8.idx.col,
				covariance: cov_c, zero_alpha_error: alpha_q == 32'd0};
		end
	end

	// output register with skid entry
	logic              out_v_q;
	oce_pkg::oce_out_t out_d_q;
	logic              skid_v_q;
	oce_pkg::oce_out_t skid_d_q;
	logic              take;

	assign take      = out_v_q && !out_stall;
	assign en        = !skid_v_q;
	assign in_stall  = skid_v_q;
	assign out_valid = out_v_q;
	assign out_item  = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (!out_v_q || take) begin
				out_v_q <= v_s9;
				out_d_q <= res_s9;
			end else if (v_s9) begin
				skid_v_q <= 1'b1;
				skid_d_q <= res_s9;
			end
		end else if (take) begin
			out_v_q  <= 1'b1;
			out_d_q  <= skid_d_q;
			skid_v_q <= 1'b0;
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int  LATENCY = 130;
	localparam longint CYCLE_LIMIT = 600000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	oce_pkg::oce_in_t    in_item = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	oce_pkg::oce_out_t   out_item;
	logic                cfg_we = 1'b0;
	oce_pkg::cfg_index_t cfg_index = oce_pkg::CFG_ALPHA_SQ;
	logic [31:0]         cfg_data = '0;

	ou_covariance_element_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [31:0] alpha_now = oce_pkg::ALPHA_RESET;
	logic [31:0] sigma_now = oce_pkg::SIGMA_RESET;
	longint unsigned exp_roots [17];

	oce_pkg::oce_in_t  pending_items [$];
	oce_pkg::oce_out_t expected_elems [$];
	int errors = 0;
	int checked = 0;
	int growth_seen = 0;
	int phases_run = 0;
	longint cycles = 0;

	function automatic longint unsigned isqrt64(longint unsigned n);
		longint unsigned res;
		longint unsigned bitw;
		res = 0;
		bitw = 64'h4000_0000_0000_0000;
		while (bitw > n) bitw = bitw >> 2;
		while (bitw != 0) begin
			if (n >= res + bitw) begin
				n = n - (res + bitw);
				res = (res >> 1) + bitw;
			end else begin
				res = res >> 1;
			end
			bitw = bitw >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned frac_pow2(logic [31:0] g);
		longint unsigned m;
		m = 64'd1 << 31;
		for (int j = 1; j <= 16; j++)
			if ((g >> (16 - j)) & 32'd1)
				m = (m * exp_roots[j] + (64'd1 << 30)) >> 31;
		return m;
	endfunction

	function automatic logic [31:0] sat_div(longint unsigned p, longint s,
		longint unsigned a);
		longint unsigned q;
		longint unsigned r;
		if (s < 0) begin
			if (s <= -64) return 32'd0;
			q = (p / a) >> int'(-s);
			return (q > 64'hFFFF_FFFF) ? oce_pkg::FULL_SCALE : q[31:0];
		end
		if (s > 64) return oce_pkg::FULL_SCALE;
		q = p / a;
		r = p % a;
		if (q > 64'hFFFF_FFFF) return oce_pkg::FULL_SCALE;
		for (longint i = 0; i < s; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= a) begin
				q = q + 1;
				r = r - a;
			end
			if (q > 64'hFFFF_FFFF) return oce_pkg::FULL_SCALE;
		end
		return q[31:0];
	endfunction

	function automatic oce_pkg::oce_out_t predict_element(oce_pkg::oce_in_t it);
		oce_pkg::oce_out_t o;
		longint rt, ct, st, d, k, e;
		longint unsigned ad, a, x, y, m, lf;
		logic [31:0] f;
		bit grow;
		o.out_row = it.row_index;
		o.out_col = it.col_index;
		o.covariance = 32'd0;
		o.zero_alpha_error = 1'b0;
		if (alpha_now == 0) begin
			o.zero_alpha_error = 1'b1;
			return o;
		end
		if (sigma_now == 0) return o;
		rt = 64'(it.row_time);
		ct = 64'(it.col_time);
		st = 64'(it.shared_time);
		d = rt + ct - 2 * st;
		grow = d < 0;
		ad = grow ? -d : d;
		a = 64'(alpha_now);
		lf = 64'(oce_pkg::LOG2E_FRAC);
		x = ((a * (ad >> 32)) << 16) + ((a * (ad & 64'hFFFF_FFFF)) >> 16);
		y = x + (x >> 32) * lf + (((x & 64'hFFFF_FFFF) * lf) >> 32);
		k = y >> 16;
		f = 32'(y & 64'hFFFF);
		if (grow) begin
			e = k;
			m = frac_pow2(f);
		end else if (f == 0) begin
			e = -k;
			m = 64'd1 << 31;
		end else begin
			e = -(k + 1);
			m = frac_pow2(32'd65536 - f);
		end
		o.covariance = sat_div(64'(sigma_now) * m, e - 16, a);
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 20)
			$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	// driver: bursts with random gaps
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_elems.push_back(predict_element(in_item));
			if (in_item.shared_time > in_item.row_time) growth_seen++;
		end
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor with its own stall pattern
	int stall_mode = 0;
	int mode_left = 50;
	always @(posedge clk) begin
		oce_pkg::oce_out_t want;
		if (out_valid && !out_stall) begin
			if (expected_elems.size() == 0) begin
				report("unexpected transaction", 32'd0, 32'd0);
			end else begin
				want = expected_elems.pop_front();
				checked++;
				if (out_item.out_row != want.out_row)
					report("out_row", 32'(out_item.out_row), 32'(want.out_row));
				if (out_item.out_col != want.out_col)
					report("out_col", 32'(out_item.out_col), 32'(want.out_col));
				if (out_item.covariance != want.covariance)
					report("covariance", out_item.covariance, want.covariance);
				if (out_item.zero_alpha_error != want.zero_alpha_error)
					report("zero_alpha_error", 32'(out_item.zero_alpha_error),
						32'(want.zero_alpha_error));
			end
		end
		mode_left--;
		if (mode_left <= 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(10, 200);
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("ou_covariance_element_top regression: fail");
			$finish;
		end
	end

	task automatic write_reg(oce_pkg::cfg_index_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == oce_pkg::CFG_ALPHA_SQ) alpha_now = v;
		else sigma_now = v;
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_elems.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_time();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom() >> $urandom_range(0, 31);
			2: return $urandom_range(0, 32'h0004_0000);
			3: return $urandom_range(0, 1) ? oce_pkg::FULL_SCALE : 32'd0;
			default: return $urandom() >> $urandom_range(8, 20);
		endcase
	endfunction

	function automatic oce_pkg::oce_in_t make_item(logic [31:0] rt, logic [31:0] ct,
		logic [31:0] st);
		oce_pkg::oce_in_t it;
		it.row_index = 8'($urandom());
		it.col_index = 8'($urandom());
		it.row_time = rt;
		it.col_time = ct;
		it.shared_time = st;
		return it;
	endfunction

	task automatic queue_random(int n);
		logic [31:0] st, rt, ct;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				// tree-like: shared time within both tip times
				st = rand_time() >> 1;
				rt = st + ($urandom() >> $urandom_range(1, 31));
				ct = st + ($urandom() >> $urandom_range(1, 31));
				pending_items.push_back(make_item(rt, ct, st));
			end else begin
				pending_items.push_back(make_item(rand_time(), rand_time(), rand_time()));
			end
		end
	endtask

	logic [31:0] alpha_set [7] = '{32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 32'd1,
		32'h0000_8000, 32'h0003_0000, 32'h0001_0000};
	logic [31:0] sigma_set [7] = '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF, 32'd1,
		32'd0, 32'h0000_4000, 32'h0010_0000};

	initial begin
		logic [63:0] n;
		logic [63:0] r;
		exp_roots[0] = 64'd1 << 32;
		for (int j = 1; j <= 16; j++) begin
			n = exp_roots[j - 1] << 31;
			r = isqrt64(n);
			if (n - r * r > r) r = r + 1;
			exp_roots[j] = r;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset settings
		pending_items.push_back(make_item(32'd0, 32'd0, 32'd0));
		pending_items.push_back(make_item(oce_pkg::FULL_SCALE, oce_pkg::FULL_SCALE,
			oce_pkg::FULL_SCALE));
		pending_items.push_back(make_item(oce_pkg::FULL_SCALE, oce_pkg::FULL_SCALE, 32'd0));
		pending_items.push_back(make_item(32'd0, 32'd0, oce_pkg::FULL_SCALE));
		pending_items.push_back(make_item(32'h0001_0000, 32'h0001_0000, 32'h0001_8000));
		pending_items.push_back(make_item(32'h0001_0000, 32'h0000_0000, 32'h0000_8000));
		pending_items.push_back(make_item(32'h0002_0000, 32'h0001_0000, 32'h0000_8000));
		pending_items.push_back(make_item(32'h0000_0001, 32'd0, 32'd0));
		pending_items.push_back(make_item(32'h0100_0000, 32'h0100_0000, 32'd0));
		pending_items.push_back(make_item(32'd0, 32'd1, 32'd1));
		for (int i = 0; i < 6; i++) begin
			pending_items.push_back(make_item($urandom(), $urandom(), $urandom()));
			pending_items[$].row_index = i[0] ? 8'hFF : 8'h00;
			pending_items[$].col_index = i[1] ? 8'h00 : 8'hFF;
		end
		queue_random(200);
		wait_drained();
		phases_run++;

		for (int p = 1; p < 7; p++) begin
			write_reg(oce_pkg::CFG_ALPHA_SQ, alpha_set[p]);
			write_reg(oce_pkg::CFG_SIGMA_SQ, sigma_set[p]);
			queue_random(200);
			wait_drained();
			phases_run++;
		end
		write_reg(oce_pkg::CFG_ALPHA_SQ, $urandom());
		write_reg(oce_pkg::CFG_SIGMA_SQ, $urandom());
		queue_random(100);
		wait_drained();
		phases_run++;

		$display("checked %0d elements over %0d rate settings, %0d with shared above row time",
			checked, phases_run, growth_seen);
		if (errors == 0) begin
			$display("ou_covariance_element_top regression: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("ou_covariance_element_top regression: fail");
		end
		$finish;
	end

endmodule

>>> ou_covariance_element_top.f
hdl/oce_pkg.sv
hdl/ou_covariance_element_top.sv
bench/testbench.sv
